// ===== rtl/core/rtpl_pkg.sv =====
`default_nettype none

package rtpl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_W            = 8;
    localparam int PRI_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int ENTRY_COUNT_W   = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TAIL     = 3'd1,
        ST_IDLE     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } op_t;

    // Signals passed from a cell to its neighbour further from the head.
    typedef struct packed {
        logic take;
        logic hit;
        logic ge;
    } link_t;

endpackage : rtpl_pkg

`default_nettype wire

// ===== rtl/core/rtpl_req_if.sv =====
`default_nettype none

interface rtpl_req_if;
    import rtpl_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [ID_W-1:0]  task_id;
    logic [PRI_W-1:0] priority_req;

    modport source (output valid, output func, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input func, input task_id, input priority_req,
                    output ready);
endinterface : rtpl_req_if

`default_nettype wire

// ===== rtl/core/rtpl_rsp_if.sv =====
`default_nettype none

interface rtpl_rsp_if;
    import rtpl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          head_task_id;
    logic [PRI_W-1:0]         head_priority;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output head_task_id,
                    output head_priority, output entry_count, input ready);
    modport sink   (input valid, input status, input head_task_id,
                    input head_priority, input entry_count, output ready);
endinterface : rtpl_rsp_if

`default_nettype wire

// ===== rtl/core/ready_task_priority_list_top.sv =====
`default_nettype none

// Channel   Direction  Payload
// req       in         func, task_id, priority_req
// rsp       out        status, head_task_id, head_priority, entry_count
// cfg       in         cfg_we, cfg_wdata (idle task id)
//
// Each transfer on req is first captured in the request registers; then the
// whole cell chain updates in parallel and the result register is loaded.
// The update waits while a previous result is still held in the result
// register; a new request is taken as soon as the update is done.
// Reset empties the list at once and sets the idle task id to zero.

module ready_task_priority_list_top #(
    parameter int MAX_ENTRIES = rtpl_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rtpl_req_if.sink                       req,
    rtpl_rsp_if.source                     rsp,
    input  wire logic                      cfg_we,
    input  wire logic [rtpl_pkg::ID_W-1:0] cfg_wdata
);
    import rtpl_pkg::*;

    localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);

    logic                     busy_reg;
    logic                     func_reg;
    logic [ID_W-1:0]          id_reg;
    logic [PRI_W-1:0]         pri_reg;
    logic [ID_W-1:0]          idle_id_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     out_valid_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [ID_W-1:0]          head_id_reg;
    logic [PRI_W-1:0]         head_pri_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;

    logic   exec;
    logic   full;
    logic   is_idle;
    op_t    op;
    link_t  links [0:MAX_ENTRIES];
    entry_t ents  [0:MAX_ENTRIES-1];
    entry_t nexts [0:MAX_ENTRIES-1];

    assign req.ready = !busy_reg;
    assign exec      = busy_reg && (!out_valid_reg || rsp.ready);
    assign full      = (count_reg == COUNT_W'(MAX_ENTRIES));
    assign is_idle   = (id_reg == idle_id_reg);

    assign op.ins_en = exec && (func_reg == FUNC_INSERT) && !full;
    assign op.rem_en = exec && (func_reg == FUNC_REMOVE) && !is_idle
                       && links[MAX_ENTRIES].hit;
    assign op.id     = id_reg;
    assign op.pri    = pri_reg;

    assign links[0] = '{take: 1'b0, hit: 1'b0, ge: 1'b0};

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = '{valid: 1'b0, id: '0, pri: '0};
        end
        else
        begin : g_mid
            assign prev_e = ents[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign next_e = '{valid: 1'b0, id: '0, pri: '0};
        end
        else
        begin : g_body
            assign next_e = ents[i+1];
        end

        rtpl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .link_in    (links[i]),
            .link_out   (links[i+1]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (ents[i]),
            .entry_next (nexts[i])
        );
    end

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        if (func_reg == FUNC_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                if ((count_reg != '0) && !links[MAX_ENTRIES].ge)
                begin
                    status_next = ST_TAIL;
                end
            end
        end
        else
        begin
            if (is_idle)
            begin
                status_next = ST_IDLE;
            end
            else if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else if (!links[MAX_ENTRIES].hit)
            begin
                status_next = ST_NOTFOUND;
            end
            else
            begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            idle_id_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                idle_id_reg <= cfg_wdata;
            end
            if (req.valid && req.ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            id_reg   <= req.task_id;
            pri_reg  <= req.priority_req;
        end
        if (exec)
        begin
            status_reg    <= status_next;
            head_id_reg   <= nexts[0].valid ? nexts[0].id : '0;
            head_pri_reg  <= nexts[0].valid ? nexts[0].pri : '0;
            out_count_reg <= ENTRY_COUNT_W'(count_next);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.head_task_id  = head_id_reg;
    assign rsp.head_priority = head_pri_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule : ready_task_priority_list_top

`default_nettype wire

// ===== rtl/core/rtpl_cell.sv =====
`default_nettype none

module rtpl_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rtpl_pkg::op_t   op,
    input  wire rtpl_pkg::link_t link_in,
    output rtpl_pkg::link_t      link_out,
    input  wire rtpl_pkg::entry_t prev_entry,
    input  wire rtpl_pkg::entry_t next_entry,
    output rtpl_pkg::entry_t     entry,
    output rtpl_pkg::entry_t     entry_next
);
    import rtpl_pkg::*;

    logic             valid_reg;
    logic [ID_W-1:0]  id_reg;
    logic [PRI_W-1:0] pri_reg;
    logic             ge;
    logic             take;
    logic             match;

    assign entry = '{valid: valid_reg, id: id_reg, pri: pri_reg};

    assign ge    = valid_reg && (pri_reg >= op.pri);
    assign take  = !valid_reg || (pri_reg >= op.pri);
    assign match = valid_reg && (id_reg == op.id);

    assign link_out = '{take: take, hit: link_in.hit | match, ge: link_in.ge | ge};

    // On insert the landing cell loads the new task and every cell behind it
    // takes the entry of its neighbour nearer the head. On remove the matching
    // cell and every cell behind it take the entry of the neighbour behind.
    always_comb
    begin
        entry_next = entry;
        if (op.ins_en && take)
        begin
            if (link_in.take)
            begin
                entry_next = prev_entry;
            end
            else
            begin
                entry_next = '{valid: 1'b1, id: op.id, pri: op.pri};
            end
        end
        else if (op.rem_en && (link_in.hit || match))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= entry_next.id;
        pri_reg <= entry_next.pri;
    end

endmodule : rtpl_cell

`default_nettype wire

// ===== tb/sv/ready_list_checker.sv =====
module ready_list_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    rtpl_req_if                         req,
    rtpl_rsp_if                         rsp,
    input  logic                        cfg_we,
    input  logic [rtpl_pkg::ID_W-1:0]   cfg_wdata,
    output logic                        drained,
    output int                          fail_count
);
    import rtpl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                  st;
        logic [ID_W-1:0]          id;
        logic [PRI_W-1:0]         pri;
        logic [ENTRY_COUNT_W-1:0] cnt;
    } list_result_t;

    logic [ID_W-1:0]  list_id  [MAX_ENTRIES_DEF];
    logic [PRI_W-1:0] list_pri [MAX_ENTRIES_DEF];
    int               list_len;
    logic [ID_W-1:0]  idle_reg;
    list_result_t     pending_results[$];

    function automatic list_result_t apply_list_op(input logic func,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [PRI_W-1:0] pri);
        list_result_t res;
        int pos;
        int i;
        res.st = ST_OK;
        pos = 0;
        if (func == FUNC_INSERT)
        begin
            if (list_len >= MAX_ENTRIES_DEF)
            begin
                res.st = ST_FULL;
            end
            else
            begin
                while (pos < list_len && list_pri[pos] < pri)
                    pos++;
                if (list_len > 0 && pos == list_len)
                    res.st = ST_TAIL;
                for (i = list_len; i > pos; i--)
                begin
                    list_id[i]  = list_id[i-1];
                    list_pri[i] = list_pri[i-1];
                end
                list_id[pos]  = id;
                list_pri[pos] = pri;
                list_len++;
            end
        end
        else if (id == idle_reg)
        begin
            res.st = ST_IDLE;
        end
        else if (list_len == 0)
        begin
            res.st = ST_EMPTY;
        end
        else
        begin
            while (pos < list_len && list_id[pos] != id)
                pos++;
            if (pos == list_len)
            begin
                res.st = ST_NOTFOUND;
            end
            else
            begin
                for (i = pos; i + 1 < list_len; i++)
                begin
                    list_id[i]  = list_id[i+1];
                    list_pri[i] = list_pri[i+1];
                end
                list_len--;
            end
        end
        res.id  = (list_len > 0) ? list_id[0] : '0;
        res.pri = (list_len > 0) ? list_pri[0] : '0;
        res.cnt = ENTRY_COUNT_W'(list_len);
        return res;
    endfunction

    // Outputs are sampled at the clock edge, so the stimulus driven with
    // nonblocking assignments is seen as it stood before the edge.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_res;
        if (!rst_n)
        begin
            list_len = 0;
            idle_reg = '0;
            pending_results.delete();
            drained <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                idle_reg = cfg_wdata;
            if (req.valid && req.ready)
                pending_results.push_back(apply_list_op(req.func, req.task_id,
                                                        req.priority_req));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d", rsp.status);
                    fail_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (rsp.status != exp_res.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.st, rsp.status);
                        fail_count++;
                    end
                    if (rsp.head_task_id != exp_res.id)
                    begin
                        $error("head_task_id: expected %0d, got %0d", exp_res.id,
                               rsp.head_task_id);
                        fail_count++;
                    end
                    if (rsp.head_priority != exp_res.pri)
                    begin
                        $error("head_priority: expected %0d, got %0d", exp_res.pri,
                               rsp.head_priority);
                        fail_count++;
                    end
                    if (rsp.entry_count != exp_res.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp_res.cnt,
                               rsp.entry_count);
                        fail_count++;
                    end
                end
            end
            drained <= (pending_results.size() == 0);
        end
    end

    initial fail_count = 0;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import rtpl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [ID_W-1:0] cfg_wdata;
    logic            drained;
    int              fail_count;
    int              cycle_count;
    bit              idling;
    bit              hold_req;
    logic [ID_W-1:0] idle_sel;
    logic [ID_W-1:0] live_ids[$];

    rtpl_req_if req_ch();
    rtpl_rsp_if rsp_ch();

    ready_task_priority_list_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ready_list_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .drained    (drained),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ready_task_priority_list_top: mismatch");
        $finish;
    end

    // The result side holds off in bursts, and once for a long stretch so
    // that the list stops taking request transfers.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic issue(input logic f, input logic [ID_W-1:0] id,
                         input logic [PRI_W-1:0] pri);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= f;
        req_ch.task_id      <= id;
        req_ch.priority_req <= pri;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic settle(input int extra);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (!drained)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_idle_id(input logic [ID_W-1:0] v);
        settle(SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        idle_sel = v;
    endtask

    task automatic random_op(input int fill_pct);
        int              r;
        int              k;
        logic [ID_W-1:0] id;
        logic [PRI_W-1:0] pri;
        r = $urandom_range(0, 99);
        if (r < fill_pct)
        begin
            id  = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 15))
                                              : ID_W'($urandom);
            pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 7) * 36)
                                              : PRI_W'($urandom);
            live_ids.push_back(id);
            if (live_ids.size() > 40)
                void'(live_ids.pop_front());
            issue(FUNC_INSERT, id, pri);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 75 && live_ids.size() > 0)
            begin
                k  = $urandom_range(0, live_ids.size() - 1);
                id = live_ids[k];
                live_ids.delete(k);
            end
            else if (r < 87)
            begin
                id = idle_sel;
            end
            else
            begin
                id = ID_W'($urandom);
            end
            issue(FUNC_REMOVE, id, PRI_W'($urandom));
        end
    endtask

    initial
    begin
        logic [ID_W-1:0] idle_plan [PHASES];
        int p;
        int k;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_INSERT;
        req_ch.task_id      <= '0;
        req_ch.priority_req <= '0;
        idling   = 1'b0;
        hold_req = 1'b0;
        idle_sel = '0;
        idle_plan[0] = 8'd255;
        idle_plan[1] = 8'd0;
        idle_plan[2] = ID_W'($urandom_range(1, 15));
        idle_plan[3] = ID_W'($urandom);
        idle_plan[4] = 8'd128;
        idle_plan[5] = ID_W'($urandom_range(0, 15));
        idle_plan[6] = 8'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(FUNC_REMOVE, 8'd0, 8'd0);
        issue(FUNC_REMOVE, 8'd5, 8'd255);
        issue(FUNC_INSERT, 8'd10, 8'd100);
        issue(FUNC_INSERT, 8'd11, 8'd100);
        issue(FUNC_INSERT, 8'd12, 8'd255);
        issue(FUNC_INSERT, 8'd13, 8'd0);
        issue(FUNC_REMOVE, 8'd99, 8'd0);
        issue(FUNC_INSERT, 8'd11, 8'd50);
        issue(FUNC_REMOVE, 8'd11, 8'd0);
        issue(FUNC_REMOVE, 8'd0, 8'd0);
        for (k = 0; k < 12; k++)
            issue(FUNC_INSERT, ID_W'(200 + k), PRI_W'(k * 20));
        issue(FUNC_INSERT, 8'd255, 8'd255);
        issue(FUNC_REMOVE, 8'd13, 8'd0);

        for (p = 0; p < PHASES; p++)
        begin
            write_idle_id(idle_plan[p]);
            idling = (p != PHASES - 1);
            if (p == 1)
                hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p != PHASES - 1)
                    idling = ((k / 60) % 3 != 2);
                random_op(((k / 40) % 2 == 0) ? 75 : 25);
            end
        end

        settle(8);
        if (fail_count == 0 && drained)
            $display("ready_task_priority_list_top: match");
        else
            $display("ready_task_priority_list_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rtpl_pkg.sv
rtl/core/rtpl_req_if.sv
rtl/core/rtpl_rsp_if.sv
rtl/core/rtpl_cell.sv
rtl/core/ready_task_priority_list_top.sv
tb/sv/ready_list_checker.sv
tb/sv/tb.sv
